### design/spnb_pkg.sv
package spnb_pkg;

    localparam int LAYER_ROUNDS = 28;
    localparam int CORE_ROUNDS  = 24;
    localparam int KEY_COUNT    = 4;

    localparam int ROUND_MAX = (LAYER_ROUNDS > CORE_ROUNDS) ? LAYER_ROUNDS : CORE_ROUNDS;
    localparam int ROUND_W   = (ROUND_MAX > 1) ? $clog2(ROUND_MAX) : 1;
    localparam int KEY_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int GEN_STEPS = 4 * (KEY_COUNT - 1);
    localparam int GEN_W     = (KEY_COUNT > 1) ? $clog2(4 * KEY_COUNT) : 3;

    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCED_COUNT = 8'd3;

    localparam logic [6:0] PERM_ROW [16] = '{
        7'd0, 7'd33, 7'd66, 7'd99, 7'd96, 7'd1, 7'd34, 7'd67,
        7'd64, 7'd97, 7'd2, 7'd35, 7'd32, 7'd65, 7'd98, 7'd3
    };

    typedef struct packed {
        logic               load_plain;
        logic               gen_load;
        logic               gen_step;
        logic               gen_store;
        logic [KEY_W-1:0]   gen_idx;
        logic               round_en;
        logic               core_sel;
        logic [ROUND_W-1:0] round_idx;
        logic [KEY_W-1:0]   key_idx;
        logic               load_out;
    } dp_cmd_t;

    function automatic logic [3:0] layer_box(input logic [3:0] x);
        logic [3:0] y;
        unique case (x)
            4'h0: y = 4'h0;
            4'h1: y = 4'h3;
            4'h2: y = 4'h7;
            4'h3: y = 4'he;
            4'h4: y = 4'hd;
            4'h5: y = 4'h4;
            4'h6: y = 4'ha;
            4'h7: y = 4'h9;
            4'h8: y = 4'hc;
            4'h9: y = 4'hf;
            4'ha: y = 4'h1;
            4'hb: y = 4'h8;
            4'hc: y = 4'hb;
            4'hd: y = 4'h2;
            4'he: y = 4'h6;
            4'hf: y = 4'h5;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    function automatic logic [3:0] core_box(input logic [3:0] x);
        logic [3:0] y;
        unique case (x)
            4'h0: y = 4'h1;
            4'h1: y = 4'h9;
            4'h2: y = 4'h6;
            4'h3: y = 4'hf;
            4'h4: y = 4'h7;
            4'h5: y = 4'hc;
            4'h6: y = 4'h8;
            4'h7: y = 4'h2;
            4'h8: y = 4'ha;
            4'h9: y = 4'he;
            4'ha: y = 4'hd;
            4'hb: y = 4'h0;
            4'hc: y = 4'h4;
            4'hd: y = 4'h3;
            4'he: y = 4'hb;
            4'hf: y = 4'h5;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    function automatic logic [5:0] round_const(input logic [4:0] r);
        logic [5:0] c;
        unique case (r)
            5'd0:  c = 6'd1;
            5'd1:  c = 6'd3;
            5'd2:  c = 6'd7;
            5'd3:  c = 6'd15;
            5'd4:  c = 6'd31;
            5'd5:  c = 6'd62;
            5'd6:  c = 6'd61;
            5'd7:  c = 6'd59;
            5'd8:  c = 6'd55;
            5'd9:  c = 6'd47;
            5'd10: c = 6'd30;
            5'd11: c = 6'd60;
            5'd12: c = 6'd57;
            5'd13: c = 6'd51;
            5'd14: c = 6'd39;
            5'd15: c = 6'd14;
            5'd16: c = 6'd29;
            5'd17: c = 6'd58;
            5'd18: c = 6'd53;
            5'd19: c = 6'd43;
            5'd20: c = 6'd22;
            5'd21: c = 6'd44;
            5'd22: c = 6'd24;
            5'd23: c = 6'd48;
            5'd24: c = 6'd33;
            5'd25: c = 6'd2;
            5'd26: c = 6'd5;
            5'd27: c = 6'd11;
            default: c = 6'd0;
        endcase
        return c;
    endfunction

    // key slot used by a round that starts mid-phase
    function automatic logic [KEY_W-1:0] key_of_round(input logic [ROUND_W-1:0] r);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < (1 << ROUND_W); i++)
        begin
            if (r == ROUND_W'(i))
            begin
                k = KEY_W'(i % KEY_COUNT);
            end
        end
        return k;
    endfunction

    function automatic logic [127:0] sub_perm(input logic [127:0] x, input logic core);
        logic [127:0] s;
        logic [127:0] o;
        s = '0;
        o = '0;
        for (int n = 0; n < 32; n++)
        begin
            s[4*n +: 4] = core ? core_box(x[4*n +: 4]) : layer_box(x[4*n +: 4]);
        end
        for (int i = 0; i < 128; i++)
        begin
            o[PERM_ROW[i % 16] + 4 * (i / 16)] = s[i];
        end
        return o;
    endfunction

    function automatic logic [127:0] spn_round(input logic [127:0] x, input logic core,
                                               input logic [4:0] r, input logic [127:0] key);
        logic [127:0] t;
        logic [5:0]   c;
        t = sub_perm(x, core);
        c = round_const(r);
        t[127] = ~t[127];
        t[23]  = t[23] ^ c[5];
        t[19]  = t[19] ^ c[4];
        t[15]  = t[15] ^ c[3];
        t[11]  = t[11] ^ c[2];
        t[7]   = t[7]  ^ c[1];
        t[3]   = t[3]  ^ c[0];
        return t ^ key;
    endfunction

    function automatic logic [127:0] keyless_round(input logic [127:0] x);
        logic [127:0] t;
        t = sub_perm(x, 1'b0);
        t[127] = ~t[127];
        return t;
    endfunction

endpackage

### design/spnb_datapath.sv
module spnb_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  spnb_pkg::dp_cmd_t              cmd,
    input  logic                           cfg_wr,
    input  logic [spnb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic [63:0]                    plain_high,
    input  logic [63:0]                    plain_low,
    output logic [63:0]                    cipher_high,
    output logic [63:0]                    cipher_low
);
    import spnb_pkg::*;

    logic [63:0]  key_high_reg, key_high_next;
    logic [63:0]  key_low_reg, key_low_next;
    logic [127:0] state_reg, state_next;
    logic [127:0] gen_reg, gen_next;
    logic [127:0] out_reg, out_next;
    logic [127:0] round_key_reg [KEY_COUNT];
    logic [127:0] keyless_val;
    logic [127:0] round_key;

    assign keyless_val = keyless_round(gen_reg);
    assign round_key   = round_key_reg[cmd.key_idx];

    always_comb
    begin
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        if (cfg_wr && cfg_index == REG_KEY_HIGH)
        begin
            key_high_next = cfg_data;
        end
        if (cfg_wr && cfg_index == REG_KEY_LOW)
        begin
            key_low_next = cfg_data;
        end
    end

    always_comb
    begin
        priority if (cmd.load_plain)
        begin
            state_next = {plain_high, plain_low};
        end
        else if (cmd.round_en)
        begin
            state_next = spn_round(state_reg, cmd.core_sel, 5'(cmd.round_idx), round_key);
        end
        else
        begin
            state_next = state_reg;
        end
    end

    always_comb
    begin
        priority if (cmd.gen_load)
        begin
            gen_next = {key_high_reg, key_low_reg};
        end
        else if (cmd.gen_step)
        begin
            gen_next = keyless_val;
        end
        else
        begin
            gen_next = gen_reg;
        end
    end

    assign out_next = cmd.load_out ? state_reg : out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            state_reg    <= '0;
            gen_reg      <= '0;
            out_reg      <= '0;
        end
        else
        begin
            key_high_reg <= key_high_next;
            key_low_reg  <= key_low_next;
            state_reg    <= state_next;
            gen_reg      <= gen_next;
            out_reg      <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.gen_load)
        begin
            round_key_reg[0] <= {key_high_reg, key_low_reg};
        end
        else if (cmd.gen_step && cmd.gen_store)
        begin
            round_key_reg[cmd.gen_idx] <= keyless_val;
        end
    end

    assign cipher_high = out_reg[127:64];
    assign cipher_low  = out_reg[63:0];

endmodule

### design/spnb_ctrl.sv
module spnb_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           plain_valid,
    output logic                           plain_stall,
    output logic                           cipher_valid,
    input  logic                           cipher_stall,
    input  logic                           cfg_wr,
    input  logic [spnb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [4:0]                     cfg_data,
    output spnb_pkg::dp_cmd_t              cmd
);
    import spnb_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_KEYGEN    = 6'b000010,
        ST_LAYER_IN  = 6'b000100,
        ST_CORE      = 6'b001000,
        ST_LAYER_OUT = 6'b010000,
        ST_HOLD      = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [KEY_W-1:0]   key_sel_reg, key_sel_next;
    logic [GEN_W-1:0]   gen_cnt_reg, gen_cnt_next;
    logic               stale_reg, stale_next;
    logic               run_mode_reg, run_mode_next;
    logic [4:0]         red_count_reg, red_count_next;
    logic               out_valid_reg, out_valid_next;

    logic [4:0]         red_n;
    logic [ROUND_W-1:0] red_start;
    state_t             run_state;
    logic [ROUND_W-1:0] run_round;
    logic [KEY_W-1:0]   run_key;
    logic [KEY_W-1:0]   key_sel_inc;

    assign red_n     = (red_count_reg > 5'(LAYER_ROUNDS)) ? 5'(LAYER_ROUNDS) : red_count_reg;
    assign red_start = ROUND_W'(LAYER_ROUNDS) - ROUND_W'(red_n);
    assign key_sel_inc = (key_sel_reg == KEY_W'(KEY_COUNT - 1)) ? '0 : key_sel_reg + 1'b1;

    // entry point of the round sequence
    always_comb
    begin
        run_round = '0;
        run_key   = '0;
        priority if (!run_mode_reg)
        begin
            run_state = ST_LAYER_IN;
        end
        else if (red_n == 5'd0)
        begin
            run_state = ST_HOLD;
        end
        else
        begin
            run_state = ST_LAYER_OUT;
            run_round = red_start;
            run_key   = key_of_round(red_start);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        key_sel_next   = key_sel_reg;
        gen_cnt_next   = gen_cnt_reg;
        stale_next     = stale_reg;
        run_mode_next  = run_mode_reg;
        red_count_next = red_count_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.round_idx  = round_reg;
        cmd.key_idx    = key_sel_reg;
        cmd.gen_idx    = KEY_W'(gen_cnt_reg[GEN_W-1:2]) + KEY_W'(1);

        if (out_valid_reg && !cipher_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (plain_valid)
                begin
                    cmd.load_plain = 1'b1;
                    if (stale_reg)
                    begin
                        cmd.gen_load = 1'b1;
                        if (KEY_COUNT > 1)
                        begin
                            state_next   = ST_KEYGEN;
                            gen_cnt_next = '0;
                        end
                        else
                        begin
                            stale_next   = 1'b0;
                            state_next   = run_state;
                            round_next   = run_round;
                            key_sel_next = run_key;
                        end
                    end
                    else
                    begin
                        state_next   = run_state;
                        round_next   = run_round;
                        key_sel_next = run_key;
                    end
                end
            end
            ST_KEYGEN:
            begin
                cmd.gen_step  = 1'b1;
                cmd.gen_store = (gen_cnt_reg[1:0] == 2'b11);
                if (gen_cnt_reg == GEN_W'(GEN_STEPS - 1))
                begin
                    stale_next   = 1'b0;
                    state_next   = run_state;
                    round_next   = run_round;
                    key_sel_next = run_key;
                end
                else
                begin
                    gen_cnt_next = gen_cnt_reg + 1'b1;
                end
            end
            ST_LAYER_IN:
            begin
                cmd.round_en = 1'b1;
                if (round_reg == ROUND_W'(LAYER_ROUNDS - 1))
                begin
                    state_next   = ST_CORE;
                    round_next   = '0;
                    key_sel_next = '0;
                end
                else
                begin
                    round_next   = round_reg + 1'b1;
                    key_sel_next = key_sel_inc;
                end
            end
            ST_CORE:
            begin
                cmd.round_en = 1'b1;
                cmd.core_sel = 1'b1;
                if (round_reg == ROUND_W'(CORE_ROUNDS - 1))
                begin
                    state_next   = ST_LAYER_OUT;
                    round_next   = '0;
                    key_sel_next = '0;
                end
                else
                begin
                    round_next   = round_reg + 1'b1;
                    key_sel_next = key_sel_inc;
                end
            end
            ST_LAYER_OUT:
            begin
                cmd.round_en = 1'b1;
                if (round_reg == ROUND_W'(LAYER_ROUNDS - 1))
                begin
                    state_next   = ST_HOLD;
                    round_next   = '0;
                    key_sel_next = '0;
                end
                else
                begin
                    round_next   = round_reg + 1'b1;
                    key_sel_next = key_sel_inc;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || !cipher_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_KEY_HIGH:      stale_next     = 1'b1;
                REG_KEY_LOW:       stale_next     = 1'b1;
                REG_RUN_MODE:      run_mode_next  = cfg_data[0];
                REG_REDUCED_COUNT: red_count_next = cfg_data;
                default:           stale_next     = stale_next;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            key_sel_reg   <= '0;
            gen_cnt_reg   <= '0;
            stale_reg     <= 1'b1;
            run_mode_reg  <= 1'b0;
            red_count_reg <= 5'(LAYER_ROUNDS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            key_sel_reg   <= key_sel_next;
            gen_cnt_reg   <= gen_cnt_next;
            stale_reg     <= stale_next;
            run_mode_reg  <= run_mode_next;
            red_count_reg <= red_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign plain_stall  = (state_reg != ST_IDLE);
    assign cipher_valid = out_valid_reg;

endmodule

### design/spn_block_cipher_128_rotating_keys_unit.sv
// 128-bit SPN block cipher with four rotating round keys.
// Plaintext channel: plain_valid/plain_stall with plain_high, plain_low; a block
// is taken when the unit is idle (plain_stall low). Ciphertext channel:
// cipher_valid/cipher_stall with cipher_high, cipher_low, held in an output
// register, so the next block can be taken while a result waits.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index, cfg_data;
// 0 key_high, 1 key_low, 2 run_mode, 3 reduced_count; other indexes ignored.
// Timing: one round per cycle through a single round unit. Full mode runs
// accept, 80 rounds and output load per block; reduced mode runs only the
// last n layer rounds. The first block after reset or after a key write first
// derives round keys 1..3 with a separate keyless round unit.
// Reset clears the controller, key and run_mode registers, sets reduced_count
// to 28 and marks the round keys stale. A stalled receiver keeps the result in
// the output register; a finished block then waits in the datapath and no new block is taken.
module spn_block_cipher_128_rotating_keys_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           plain_valid,
    output logic                           plain_stall,
    input  logic [63:0]                    plain_high,
    input  logic [63:0]                    plain_low,
    output logic                           cipher_valid,
    input  logic                           cipher_stall,
    output logic [63:0]                    cipher_high,
    output logic [63:0]                    cipher_low,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [spnb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data
);
    import spnb_pkg::*;

    dp_cmd_t cmd;
    logic    cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    spnb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .plain_valid  (plain_valid),
        .plain_stall  (plain_stall),
        .cipher_valid (cipher_valid),
        .cipher_stall (cipher_stall),
        .cfg_wr       (cfg_wr),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data[4:0]),
        .cmd          (cmd)
    );

    spnb_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_wr      (cfg_wr),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .plain_high  (plain_high),
        .plain_low   (plain_low),
        .cipher_high (cipher_high),
        .cipher_low  (cipher_low)
    );

endmodule

### design/spnb_checker.sv
module spnb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           plain_valid,
    input logic                           plain_stall,
    input logic [63:0]                    plain_high,
    input logic [63:0]                    plain_low,
    input logic                           cipher_valid,
    input logic                           cipher_stall,
    input logic [63:0]                    cipher_high,
    input logic [63:0]                    cipher_low,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [spnb_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [63:0]                    cfg_data
);
    import spnb_pkg::*;

    logic plain_txn;
    logic [CFG_IDX_W-1:0] cfg_index_seen;
    logic [63:0] plain_sum;

    assign plain_txn      = plain_valid && !plain_stall;
    assign cfg_index_seen = cfg_valid ? cfg_index : '0;
    assign plain_sum      = plain_high ^ plain_low ^ cfg_data ^ 64'(cfg_index_seen);

    // busy right after a transaction is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        plain_txn |=> plain_stall)
        else $error("input taken while a block is in flight");

    // a result never shows up in the cycle after a transaction
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        plain_txn |=> !$rose(cipher_valid))
        else $error("result appeared too early");

    // a new result coincides with the unit going idle
    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cipher_valid) |-> !plain_stall)
        else $error("result posted while unit still busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cipher_valid && cipher_stall |=> cipher_valid && $stable(cipher_high)
            && $stable(cipher_low))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && (plain_sum == plain_sum) |-> cfg_ready)
        else $error("config write refused");

endmodule

bind spn_block_cipher_128_rotating_keys_unit spnb_checker u_spnb_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import spnb_pkg::*;

    localparam int LAYER_N   = 28;
    localparam int CORE_N    = 24;
    localparam int KEY_SLOTS = 4;

    // nibble k of the constant is the S-box output for input k
    localparam logic [63:0] LAYER_SBOX = 64'h562b81fc9a4de730;
    localparam logic [63:0] CORE_SBOX  = 64'h5b340dea28c7f691;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } block128_t;

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 plain_valid  = 1'b0;
    logic                 plain_stall;
    logic [63:0]          plain_high   = '0;
    logic [63:0]          plain_low    = '0;
    logic                 cipher_valid;
    logic                 cipher_stall = 1'b0;
    logic [63:0]          cipher_high;
    logic [63:0]          cipher_low;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [63:0]          cfg_data     = '0;

    // shadow copy of the configuration and round keys
    logic [63:0]  key_high_m      = '0;
    logic [63:0]  key_low_m       = '0;
    logic         run_mode_m      = 1'b0;
    logic [4:0]   reduced_count_m = 5'd28;
    logic [127:0] round_keys [KEY_SLOTS];
    logic         keys_stale      = 1'b1;

    block128_t plain_pending [$];
    block128_t cipher_expect [$];
    block128_t next_plain;
    block128_t predicted;
    block128_t oldest;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int mismatch_count  = 0;

    spn_block_cipher_128_rotating_keys_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .plain_valid  (plain_valid),
        .plain_stall  (plain_stall),
        .plain_high   (plain_high),
        .plain_low    (plain_low),
        .cipher_valid (cipher_valid),
        .cipher_stall (cipher_stall),
        .cipher_high  (cipher_high),
        .cipher_low   (cipher_low),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    function automatic logic [127:0] sub_permute(logic [127:0] x, bit use_core);
        logic [127:0] s;
        logic [127:0] o;
        int           j;
        int           d;
        o = '0;
        for (int n = 0; n < 32; n++)
        begin
            s[4*n +: 4] = use_core ? CORE_SBOX[4*x[4*n +: 4] +: 4]
                                   : LAYER_SBOX[4*x[4*n +: 4] +: 4];
        end
        // row entry for j = 4a+b is 32*((b-a) mod 4) + b
        for (int i = 0; i < 128; i++)
        begin
            j = i % 16;
            d = 32 * (((j % 4) + 4 - (j / 4)) % 4) + (j % 4) + 4 * (i / 16);
            o[d] = s[i];
        end
        return o;
    endfunction

    // round constants follow a 6-bit shift register with xnor feedback
    function automatic logic [5:0] round_const_at(int r);
        logic [5:0] c;
        c = 6'd1;
        for (int k = 0; k < r; k++)
        begin
            c = {c[4:0], ~(c[5] ^ c[4])};
        end
        return c;
    endfunction

    function automatic logic [127:0] cipher_round(logic [127:0] x, bit use_core, int r);
        logic [127:0] t;
        logic [5:0]   c;
        t = sub_permute(x, use_core);
        c = round_const_at(r);
        t[127] = ~t[127];
        t[23]  = t[23] ^ c[5];
        t[19]  = t[19] ^ c[4];
        t[15]  = t[15] ^ c[3];
        t[11]  = t[11] ^ c[2];
        t[7]   = t[7]  ^ c[1];
        t[3]   = t[3]  ^ c[0];
        return t ^ round_keys[r % KEY_SLOTS];
    endfunction

    function automatic void derive_round_keys();
        logic [127:0] t;
        t = {key_high_m, key_low_m};
        round_keys[0] = t;
        for (int k = 1; k < KEY_SLOTS; k++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                t = sub_permute(t, 1'b0);
                t[127] = ~t[127];
            end
            round_keys[k] = t;
        end
        keys_stale = 1'b0;
    endfunction

    function automatic block128_t encrypt_block(block128_t p);
        logic [127:0] st;
        int           n;
        block128_t    res;
        if (keys_stale)
        begin
            derive_round_keys();
        end
        st = {p.hi, p.lo};
        if (run_mode_m)
        begin
            n = (reduced_count_m > LAYER_N) ? LAYER_N : int'(reduced_count_m);
            for (int r = LAYER_N - n; r < LAYER_N; r++)
            begin
                st = cipher_round(st, 1'b0, r);
            end
        end
        else
        begin
            for (int r = 0; r < LAYER_N; r++)
            begin
                st = cipher_round(st, 1'b0, r);
            end
            for (int r = 0; r < CORE_N; r++)
            begin
                st = cipher_round(st, 1'b1, r);
            end
            for (int r = 0; r < LAYER_N; r++)
            begin
                st = cipher_round(st, 1'b0, r);
            end
        end
        res.hi = st[127:64];
        res.lo = st[63:0];
        return res;
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // plaintext driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plain_valid <= 1'b0;
        end
        else
        begin
            if (plain_valid && !plain_stall)
            begin
                predicted = encrypt_block('{hi: plain_high, lo: plain_low});
                cipher_expect.push_back(predicted);
            end
            if (!(plain_valid && plain_stall))
            begin
                if (plain_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_plain = plain_pending.pop_front();
                    plain_valid <= 1'b1;
                    plain_high  <= next_plain.hi;
                    plain_low   <= next_plain.lo;
                end
                else
                begin
                    plain_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_stall <= 1'b0;
        end
        else
        begin
            cipher_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ciphertext monitor
    always @(posedge clk)
    begin
        if (rst_n && cipher_valid && !cipher_stall)
        begin
            if (cipher_expect.size() == 0)
            begin
                $error("unexpected ciphertext transaction: %h %h", cipher_high, cipher_low);
                mismatch_count++;
            end
            else
            begin
                oldest = cipher_expect.pop_front();
                if (cipher_high !== oldest.hi)
                begin
                    $error("cipher_high: expected %h, got %h", oldest.hi, cipher_high);
                    mismatch_count++;
                end
                if (cipher_low !== oldest.lo)
                begin
                    $error("cipher_low: expected %h, got %h", oldest.lo, cipher_low);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic set_idling(idling_t mode);
        case (mode)
            IDLE_NONE:     begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 61; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 61; end
            default:       begin sender_idle_pct = 16; recv_stall_pct = 16; end
        endcase
    endtask

    task automatic push_plain(logic [63:0] hi, logic [63:0] lo);
        plain_pending.push_back('{hi: hi, lo: lo});
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (plain_pending.size() != 0 || plain_valid || cipher_expect.size() != 0);
    endtask

    // call right after a rising edge; leaves cfg_valid high at the accepting edge
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_KEY_HIGH:      begin key_high_m = data; keys_stale = 1'b1; end
            REG_KEY_LOW:       begin key_low_m  = data; keys_stale = 1'b1; end
            REG_RUN_MODE:      run_mode_m      = data[0];
            REG_REDUCED_COUNT: reduced_count_m = data[4:0];
            default:           ;
        endcase
    endtask

    initial
    begin
        int count;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: zero key, full cipher
        set_idling(IDLE_NONE);
        push_plain('0, '0);
        push_plain('1, '1);
        push_plain(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        push_plain(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
        wait_idle();

        @(posedge clk);
        cfg_write(REG_KEY_HIGH, '1);
        cfg_write(REG_KEY_LOW, '0);
        cfg_valid <= 1'b0;
        push_plain('0, '1);
        push_plain('1, '0);
        wait_idle();

        @(posedge clk);
        cfg_write(REG_KEY_HIGH, '0);
        cfg_write(REG_KEY_LOW, '1);
        cfg_valid <= 1'b0;
        push_plain(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        wait_idle();

        // reduced count of zero passes the plaintext through
        @(posedge clk);
        cfg_write(REG_RUN_MODE, 64'd1);
        cfg_write(REG_REDUCED_COUNT, 64'd0);
        cfg_valid <= 1'b0;
        push_plain('1, '0);
        push_plain(64'hdead_beef_0000_ffff, 64'h1234_5678_9abc_def0);
        wait_idle();

        // oversized count saturates
        @(posedge clk);
        cfg_write(REG_REDUCED_COUNT, 64'hffff_ffff_ffff_ffff);
        cfg_valid <= 1'b0;
        push_plain('0, '0);
        push_plain('1, '1);
        wait_idle();

        @(posedge clk);
        cfg_write(REG_REDUCED_COUNT, 64'd1);
        cfg_valid <= 1'b0;
        push_plain('0, '0);
        push_plain(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        wait_idle();

        // unknown indexes are ignored
        @(posedge clk);
        cfg_write(REG_REDUCED_COUNT, 64'd28);
        cfg_write(CFG_IDX_W'(4), '1);
        cfg_write(CFG_IDX_W'(255), '1);
        cfg_valid <= 1'b0;
        push_plain('1, '1);
        push_plain(64'h0f0f_0f0f_0f0f_0f0f, 64'hf0f0_f0f0_f0f0_f0f0);
        wait_idle();

        @(posedge clk);
        cfg_write(REG_RUN_MODE, 64'hffff_ffff_ffff_fffe);
        cfg_valid <= 1'b0;
        push_plain({$urandom, $urandom}, {$urandom, $urandom});
        wait_idle();

        for (int ph = 0; ph < 12; ph++)
        begin
            set_idling(idling_t'(ph % 4));
            @(posedge clk);
            case ($urandom_range(3))
                1: cfg_write(REG_KEY_HIGH, rand_word());
                2: cfg_write(REG_KEY_LOW, rand_word());
                3:
                begin
                    cfg_write(REG_KEY_HIGH, rand_word());
                    cfg_write(REG_KEY_LOW, rand_word());
                end
                default: ;
            endcase
            if ($urandom_range(99) < 40)
            begin
                cfg_write(REG_RUN_MODE, {$urandom, $urandom} & ~64'd1);
            end
            else
            begin
                cfg_write(REG_RUN_MODE, {$urandom, $urandom} | 64'd1);
                cfg_write(REG_REDUCED_COUNT,
                          ({$urandom, $urandom} & ~64'd31) | 64'($urandom_range(31)));
            end
            if ($urandom_range(3) == 0)
            begin
                cfg_write(CFG_IDX_W'($urandom_range(4, 255)), rand_word());
            end
            cfg_valid <= 1'b0;

            count = $urandom_range(36, 48);
            for (int k = 0; k < count; k++)
            begin
                push_plain(rand_word(), rand_word());
                // sender holds off mid-phase until every ciphertext is back
                if (ph == 5 && k == count / 2)
                begin
                    wait_idle();
                end
            end
            wait_idle();
        end

        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && cipher_expect.size() == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

### files.f
design/spnb_pkg.sv
design/spnb_datapath.sv
design/spnb_ctrl.sv
design/spn_block_cipher_128_rotating_keys_unit.sv
design/spnb_checker.sv
tb/sv/testbench.sv
